// ===== hw/rtl/ipg_pkg.sv =====
package ipg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned STOPS      = 6;
  localparam int unsigned SEG_W      = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [RGB_W-1:0]     rgb_t;
  typedef rgb_t [STOPS-1:0]     palette_t;

  localparam cfg_idx_t REG_MAX_COUNT = 3'd0;
  localparam cfg_idx_t REG_PALETTE_0 = 3'd1;

  localparam limit_t MAX_COUNT_RESET = 16'd100;

  localparam palette_t PALETTE_RESET = {
    24'hFFFFFF, 24'hFF00FF, 24'h8000FF, 24'h00FFFF, 24'h0000FF, 24'h000000
  };

endpackage

// ===== hw/rtl/iteration_palette_gradient.sv =====
// Escape-time palette gradient: turns one iteration count per beat into an RGB colour.
// The input channel (in_valid_i, in_ready_o, count_i) takes one count per beat, and
// the output channel (out_valid_o, out_ready_i, rgb_o) returns exactly one colour per
// count, in order. Counts at or above max_count give black; other counts are spread
// over five segments between six palette stops and blended linearly per channel.
// Configuration goes through cfg_we_i, cfg_idx_i and cfg_data_i: index 0 is max_count,
// indices 1 to 6 are the palette stops. Write it only while the pipeline is empty.
// A beat passes one input stage, loaded at the accepting edge, one stage for each of
// the FRAC_BITS + 3 quotient bits of the restoring divider, and two blend stages.
// Throughput is one beat per cycle while the receiver holds out_ready_i high; the
// divider chain is what sets the depth.
// Reset empties every stage and restores max_count to 100 and the default palette.
// When the receiver stalls, the finished colour holds on rgb_o and earlier stages
// keep filling any empty slots; in_ready_o falls only once every stage holds a beat.
module iteration_palette_gradient #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COUNT_WIDTH-1:0]        count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ipg_pkg::rgb_t                 rgb_o,
  input  logic                          cfg_we_i,
  input  ipg_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [ipg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DW = (COUNT_WIDTH > ipg_pkg::LIMIT_W) ? COUNT_WIDTH
                                                                 : ipg_pkg::LIMIT_W;
  localparam int unsigned RW = DW + 3;
  localparam int unsigned QW = FRAC_BITS + 3;

  ipg_pkg::limit_t   limit_q;
  ipg_pkg::palette_t palette_q;

  logic [DW-1:0] count_ext;
  logic [DW-1:0] limit_ext;
  logic          load_f;

  logic          valid_w [QW+1];
  logic          ready_w [QW+1];
  logic [RW-1:0] rem_w   [QW+1];
  logic [QW-1:0] quo_w   [QW+1];
  logic          black_w [QW+1];

  logic          front_valid_q;
  logic [RW-1:0] front_rem_q;
  logic          front_black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= ipg_pkg::MAX_COUNT_RESET;
      palette_q <= ipg_pkg::PALETTE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ipg_pkg::REG_MAX_COUNT) begin
        limit_q <= cfg_data_i[ipg_pkg::LIMIT_W-1:0];
      end
      for (int i = 0; i < ipg_pkg::STOPS; i++) begin
        if (cfg_idx_i == ipg_pkg::cfg_idx_t'(ipg_pkg::REG_PALETTE_0 + i)) begin
          palette_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign count_ext  = DW'(count_i);
  assign limit_ext  = DW'(limit_q);
  assign in_ready_o = ~front_valid_q | ready_w[0];
  assign load_f     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_f) begin
      front_rem_q   <= RW'({count_ext, 2'b00}) + RW'(count_ext);
      front_black_q <= (count_ext >= limit_ext);
    end
  end

  assign valid_w[0] = front_valid_q;
  assign rem_w[0]   = front_rem_q;
  assign quo_w[0]   = '0;
  assign black_w[0] = front_black_q;

  for (genvar s = 0; s < QW; s++) begin : g_div
    ipg_div_stage #(
      .DW   (DW),
      .F    (FRAC_BITS),
      .STEP (s)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[s]),
      .in_ready_o  (ready_w[s]),
      .rem_i       (rem_w[s]),
      .quo_i       (quo_w[s]),
      .black_i     (black_w[s]),
      .limit_i     (limit_ext),
      .out_valid_o (valid_w[s+1]),
      .out_ready_i (ready_w[s+1]),
      .rem_o       (rem_w[s+1]),
      .quo_o       (quo_w[s+1]),
      .black_o     (black_w[s+1])
    );
  end

  ipg_blend #(
    .F (FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_w[QW]),
    .in_ready_o  (ready_w[QW]),
    .quo_i       (quo_w[QW]),
    .black_i     (black_w[QW]),
    .palette_i   (palette_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rgb_o       (rgb_o)
  );

endmodule

// ===== hw/rtl/ipg_div_stage.sv =====
module ipg_div_stage #(
  parameter int unsigned DW   = 16,
  parameter int unsigned F    = 8,
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [DW+2:0]   rem_i,
  input  logic [F+2:0]    quo_i,
  input  logic            black_i,
  input  logic [DW-1:0]   limit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [DW+2:0]   rem_o,
  output logic [F+2:0]    quo_o,
  output logic            black_o
);

  localparam int unsigned RW   = DW + 3;
  localparam int unsigned QW   = F + 3;
  localparam int unsigned QBIT = QW - 1 - STEP;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] dvs;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic          take;
  logic          load;

  logic          valid_q;
  logic [RW-1:0] rem_q;
  logic [QW-1:0] quo_q;
  logic          black_q;

  // The first three steps produce the integer part, the rest one fraction bit each.
  if (STEP < 3) begin : g_int
    assign rem_sh = rem_i;
    assign dvs    = {3'b000, limit_i} << (2 - STEP);
  end else begin : g_frac
    assign rem_sh = {rem_i[RW-2:0], 1'b0};
    assign dvs    = {3'b000, limit_i};
  end

  always_comb begin
    take        = (rem_sh >= dvs);
    rem_d       = take ? (rem_sh - dvs) : rem_sh;
    quo_d       = quo_i;
    quo_d[QBIT] = take;
  end

  assign in_ready_o = ~valid_q | out_ready_i;
  assign load       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      black_q <= black_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign quo_o       = quo_q;
  assign black_o     = black_q;

endmodule

// ===== hw/rtl/ipg_blend.sv =====
module ipg_blend #(
  parameter int unsigned F = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [F+2:0]      quo_i,
  input  logic              black_i,
  input  ipg_pkg::palette_t palette_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipg_pkg::rgb_t     rgb_o
);

  localparam int unsigned PW = F + ipg_pkg::CH_W + 1;

  logic [ipg_pkg::SEG_W-1:0] seg;
  logic [F-1:0]              frac;
  logic [F:0]                wlo;
  ipg_pkg::rgb_t             lo;
  ipg_pkg::rgb_t             hi;
  logic [PW-1:0]             pa_d [3];
  logic [PW-1:0]             pb_d [3];
  logic [PW:0]               sum  [3];
  ipg_pkg::rgb_t             rgb_d;
  logic                      ready_p;
  logic                      load_p;
  logic                      load_o;

  logic                      valid_p_q;
  logic                      black_p_q;
  logic [PW-1:0]             pa_q [3];
  logic [PW-1:0]             pb_q [3];
  logic                      valid_o_q;
  ipg_pkg::rgb_t             rgb_q;

  always_comb begin
    seg  = quo_i[F+2:F];
    frac = quo_i[F-1:0];
    wlo  = {1'b1, {F{1'b0}}} - {1'b0, frac};
    lo   = palette_i[seg];
    hi   = palette_i[seg + 3'd1];
    for (int c = 0; c < 3; c++) begin
      pa_d[c] = PW'(lo[c*ipg_pkg::CH_W +: ipg_pkg::CH_W]) * PW'(wlo);
      pb_d[c] = PW'(hi[c*ipg_pkg::CH_W +: ipg_pkg::CH_W]) * PW'(frac);
    end
  end

  always_comb begin
    rgb_d = '0;
    for (int c = 0; c < 3; c++) begin
      sum[c] = {1'b0, pa_q[c]} + {1'b0, pb_q[c]};
      rgb_d[c*ipg_pkg::CH_W +: ipg_pkg::CH_W] = sum[c][F +: ipg_pkg::CH_W];
    end
    if (black_p_q) begin
      rgb_d = '0;
    end
  end

  assign ready_p    = ~valid_o_q | out_ready_i;
  assign in_ready_o = ~valid_p_q | ready_p;
  assign load_p     = in_valid_i & in_ready_o;
  assign load_o     = valid_p_q & ready_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
      valid_o_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_p_q <= in_valid_i;
      end
      if (ready_p) begin
        valid_o_q <= valid_p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_p) begin
      black_p_q <= black_i;
      for (int c = 0; c < 3; c++) begin
        pa_q[c] <= pa_d[c];
        pb_q[c] <= pb_d[c];
      end
    end
    if (load_o) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = valid_o_q;
  assign rgb_o       = rgb_q;

endmodule

// ===== hw/rtl/ipg_checker.sv =====
module ipg_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ipg_pkg::rgb_t rgb_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rgb_o))
    else $error("output beat changed while stalled");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without an output stall");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output beat present straight after reset");

endmodule

bind iteration_palette_gradient ipg_checker u_ipg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rgb_o       (rgb_o)
);

// ===== dv/tb_iteration_palette_gradient.sv =====
`timescale 1ns / 1ps

module tb_iteration_palette_gradient;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned PIPE_DEPTH = FRAC_W + 6;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_BEATS = 125;
  localparam int unsigned PHASES = 6;
  localparam ipg_pkg::cfg_idx_t REG_UNUSED = 3'd7;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    ipg_pkg::cfg_idx_t              idx;
    logic [ipg_pkg::CFG_DATA_W-1:0] data;
    logic [COUNT_W-1:0]             count;
    bit                             known;
    ipg_pkg::rgb_t                  rgb;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COUNT_W-1:0] count_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ipg_pkg::rgb_t rgb;
  logic cfg_we = 1'b0;
  ipg_pkg::cfg_idx_t cfg_idx = '0;
  logic [ipg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ipg_pkg::rgb_t held_rgb = '0;
  ipg_pkg::rgb_t want_rgb;
  ipg_pkg::rgb_t colour_q[$];
  ipg_pkg::limit_t max_limit = ipg_pkg::MAX_COUNT_RESET;
  ipg_pkg::rgb_t stops [ipg_pkg::STOPS];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  row_t plan [];

  iteration_palette_gradient #(
    .COUNT_WIDTH(COUNT_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .count_i    (count_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .rgb_o      (rgb),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic ipg_pkg::rgb_t predict_colour(input logic [COUNT_W-1:0] c);
    logic [31:0] scaled;
    logic [2:0] seg;
    logic [7:0] frac;
    ipg_pkg::rgb_t lo;
    ipg_pkg::rgb_t hi;
    ipg_pkg::rgb_t colour;
    int unsigned sum;
    if (max_limit == 0 || c >= max_limit) return '0;
    scaled = ((32'(c) * 32'd5) << FRAC_W) / 32'(max_limit);
    seg = scaled[FRAC_W+2:FRAC_W];
    frac = scaled[FRAC_W-1:0];
    lo = stops[seg];
    hi = stops[seg+1];
    for (int ch = 0; ch < 3; ch++) begin
      sum = lo[8*ch+:8] * (256 - frac) + hi[8*ch+:8] * frac;
      colour[8*ch+:8] = sum[15:8];
    end
    return colour;
  endfunction

  function automatic row_t known_row(input logic [COUNT_W-1:0] c,
                                     input ipg_pkg::rgb_t want);
    return '{ROW_BEAT, ipg_pkg::REG_MAX_COUNT, '0, c, 1'b1, want};
  endfunction

  function automatic row_t open_row(input logic [COUNT_W-1:0] c);
    return '{ROW_BEAT, ipg_pkg::REG_MAX_COUNT, '0, c, 1'b0, '0};
  endfunction

  function automatic row_t write_row(input ipg_pkg::cfg_idx_t idx,
                                     input logic [ipg_pkg::CFG_DATA_W-1:0] d);
    return '{ROW_WRITE, idx, d, '0, 1'b0, '0};
  endfunction

  task automatic report_mismatch(input string what, input ipg_pkg::rgb_t got,
                                 input ipg_pkg::rgb_t want);
    if (errors < 40) begin
      $display("%0t: %s: rgb_o %06h, expected %06h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task automatic write_reg(input ipg_pkg::cfg_idx_t idx,
                           input logic [ipg_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    if (idx == ipg_pkg::REG_MAX_COUNT) begin
      max_limit = d[ipg_pkg::LIMIT_W-1:0];
    end else if (idx >= ipg_pkg::REG_PALETTE_0 &&
                 idx < ipg_pkg::REG_PALETTE_0 + ipg_pkg::STOPS) begin
      stops[idx - ipg_pkg::REG_PALETTE_0] = d[ipg_pkg::RGB_W-1:0];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // The first edge lets a beat accepted at this very edge reach the queue.
  task automatic wait_for_colours();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (colour_q.size() != 0);
  endtask

  task automatic send_count(input logic [COUNT_W-1:0] c, input ipg_pkg::rgb_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    count_in <= c;
    held_rgb <= want;
    do @(posedge clk_i); while (!in_ready);
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (colour_q.size() == 0) begin
          report_mismatch("colour with no count waiting", rgb, '0);
        end else begin
          want_rgb = colour_q.pop_front();
          if (rgb !== want_rgb) begin
            report_mismatch("wrong colour", rgb, want_rgb);
          end
        end
      end
      if (in_valid && in_ready) begin
        colour_q.push_back(held_rgb);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [COUNT_W-1:0] c;
    ipg_pkg::limit_t lim;
    for (int k = 0; k < ipg_pkg::STOPS; k++) stops[k] = ipg_pkg::PALETTE_RESET[k];
    plan = '{
      known_row(16'd0, 24'h000000),
      known_row(16'd10, 24'h00007F),
      known_row(16'd20, 24'h0000FF),
      known_row(16'd40, 24'h00FFFF),
      known_row(16'd60, 24'h8000FF),
      known_row(16'd80, 24'hFF00FF),
      known_row(16'd99, 24'hFFF2FF),
      known_row(16'd100, 24'h000000),
      known_row(16'hFFFF, 24'h000000),
      write_row(REG_UNUSED, 24'hFFFFFF),
      open_row(16'd50),
      open_row(16'd1),
      write_row(ipg_pkg::REG_MAX_COUNT, 24'hFF0000),
      known_row(16'd0, 24'h000000),
      known_row(16'hFFFF, 24'h000000),
      write_row(ipg_pkg::REG_MAX_COUNT, 24'hFFFFFF),
      open_row(16'hFFFE),
      open_row(16'd13107),
      write_row(ipg_pkg::REG_PALETTE_0, 24'hFFFFFF),
      known_row(16'd0, 24'hFFFFFF),
      write_row(ipg_pkg::cfg_idx_t'(ipg_pkg::REG_PALETTE_0 + 5), 24'h000000),
      open_row(16'hFFF0),
      write_row(ipg_pkg::REG_MAX_COUNT, 24'h000001),
      known_row(16'd0, 24'hFFFFFF),
      known_row(16'd1, 24'h000000),
      write_row(ipg_pkg::REG_MAX_COUNT, 24'h000002),
      open_row(16'd1)
    };

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 61;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_for_colours();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_count(plan[i].count,
                   plan[i].known ? plan[i].rgb : predict_colour(plan[i].count));
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 61 : 0;
      recv_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 36 : 0;
      case (phase)
        0: lim = ipg_pkg::limit_t'($urandom_range(2, 400));
        1: lim = 16'hFFFF;
        2: lim = 16'd1;
        3: lim = ipg_pkg::limit_t'($urandom_range(2, 65535));
        4: lim = ipg_pkg::limit_t'($urandom_range(2, 1000));
        default: lim = 16'hFFFF;
      endcase
      wait_for_colours();
      write_reg(REG_UNUSED, ipg_pkg::CFG_DATA_W'($urandom));
      write_reg(ipg_pkg::REG_MAX_COUNT, {8'($urandom_range(0, 255)), lim});
      for (int k = 0; k < ipg_pkg::STOPS; k++) begin
        write_reg(ipg_pkg::cfg_idx_t'(ipg_pkg::REG_PALETTE_0 + k),
                  (phase == 1) ? 24'hFFFFFF : (phase == 3) ? 24'h000000
                                            : ipg_pkg::CFG_DATA_W'($urandom));
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Partway through, hold the input back until the pipeline has emptied.
        if (n == PHASE_BEATS / 2) wait_for_colours();
        case ($urandom_range(0, 9))
          7: c = COUNT_W'($urandom_range(max_limit, 65535));
          8: c = COUNT_W'($urandom);
          9: begin
            case ($urandom_range(0, 2))
              0: c = '0;
              1: c = max_limit - 1'b1;
              default: c = max_limit;
            endcase
          end
          default: c = COUNT_W'($urandom_range(0, max_limit - 1));
        endcase
        send_count(c, predict_colour(c));
      end
    end

    wait_for_colours();
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
